@@ hw/rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk with reset rst_n.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every clock edge out of reset
`define PDPE_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// antecedent implies consequent on the next clock edge
`define PDPE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ hw/rtl/pdpe_pkg.sv @@
// ----------------------------------------------------------------------------
// pdpe_pkg
// Types, constants and helpers of the page download protocol engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pdpe_pkg;

    localparam int PAGE_BYTES = 128;
    localparam int FACES      = 6;
    localparam int NWORDS     = ((PAGE_BYTES / 2) > 64) ? 64 : (PAGE_BYTES / 2);
    localparam int BANK_D     = PAGE_BYTES / 2;
    localparam int BANK_AW    = $clog2(BANK_D);
    localparam int SRC_W      = $clog2(FACES + 1);

    localparam logic [2:0] ACT_BURN     = 3'd0;
    localparam logic [2:0] ACT_PULL     = 3'd1;
    localparam logic [2:0] ACT_PUSH     = 3'd2;
    localparam logic [2:0] ACT_SEED     = 3'd3;
    localparam logic [2:0] ACT_BAD      = 3'd4;
    localparam logic [2:0] ACT_ORDER    = 3'd5;
    localparam logic [2:0] ACT_CHECKSUM = 3'd6;
    localparam logic [2:0] ACT_TIMEOUT  = 3'd7;

    localparam logic [1:0] MODE_BYTE  = 2'd0;
    localparam logic [1:0] MODE_TICK  = 2'd1;
    localparam logic [1:0] MODE_START = 2'd2;

    localparam logic [2:0] REG_PUSH_HDR   = 3'd0;
    localparam logic [2:0] REG_SEED_HDR   = 3'd1;
    localparam logic [2:0] REG_PULL_HDR   = 3'd2;
    localparam logic [2:0] REG_DONE_RLD   = 3'd3;
    localparam logic [2:0] REG_SEED_RLD   = 3'd4;
    localparam logic [2:0] REG_ROOT_EN    = 3'd5;
    localparam logic [2:0] REG_ROOT_PAGES = 3'd6;
    localparam logic [2:0] REG_ROOT_CS    = 3'd7;

    localparam logic [7:0] STAGGER_TAB [8] = '{8'd2, 8'd3, 8'd4, 8'd5, 8'd1, 8'd0, 8'd0, 8'd0};

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_MAIN,
        S_SEED,
        S_TMO,
        S_BURN_RD,
        S_BURN_LD
    } ctrl_state_t;

    typedef enum logic [2:0] {
        LD_NONE,
        LD_MAIN,
        LD_SEED,
        LD_TMO,
        LD_BURN
    } load_kind_t;

    typedef struct packed {
        logic       take_in;
        load_kind_t load;
        logic       load_last;
        logic       rd_en;
        logic       idx_clr;
        logic       idx_inc;
    } cmd_t;

    typedef struct packed {
        logic dec_main;
        logic dec_seed;
        logic dec_tmo;
        logic dec_burn;
        logic out_free;
        logic idx_last;
    } sts_t;

    function automatic logic [2:0] stagger(input logic [2:0] f);
        logic [7:0] n;
        n = STAGGER_TAB[f];
        return (n < 8'(FACES)) ? n[2:0] : 3'd0;
    endfunction

endpackage

@@ hw/rtl/pdpe_item_if.sv @@
// ----------------------------------------------------------------------------
// pdpe_item_if
// Input item channel: packet byte, timer tick or start.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface pdpe_item_if;
    logic       valid;
    logic       ready;
    logic [1:0] mode;
    logic [2:0] face;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, mode, face, data_byte, last_byte, input ready);
    modport sink   (input valid, mode, face, data_byte, last_byte, output ready);
endinterface

@@ hw/rtl/pdpe_result_if.sv @@
// ----------------------------------------------------------------------------
// pdpe_result_if
// Result item channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface pdpe_result_if;
    logic        valid;
    logic        ready;
    logic [2:0]  action;
    logic [2:0]  target_face;
    logic [7:0]  page;
    logic [5:0]  word_index;
    logic [15:0] word_data;
    logic [7:0]  seed_pages;
    logic [15:0] seed_checksum;
    logic        complete;
    logic        last;

    modport source (output valid, action, target_face, page, word_index, word_data,
                    seed_pages, seed_checksum, complete, last, input ready);
    modport sink   (input valid, action, target_face, page, word_index, word_data,
                    seed_pages, seed_checksum, complete, last, output ready);
endinterface

@@ hw/rtl/pdpe_cfg_if.sv @@
// ----------------------------------------------------------------------------
// pdpe_cfg_if
// Configuration register write channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface pdpe_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [15:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ hw/rtl/page_download_protocol_engine.sv @@
// ----------------------------------------------------------------------------
// page_download_protocol_engine
// Seed/pull/push page download protocol over received packet bytes and ticks.
// ----------------------------------------------------------------------------
// An input transfer is followed by a decide state, then for a result a load state
// that writes the result register; each burn word has a read and a load state.
// A stalled output holds the load state. A new item is taken only in idle, so one
// item ends before the next; a good push drains 64 words via the single read port.
// Reset: rst_n asynchronous, active low; clears control and protocol state,
// loads register defaults; page buffer contents are undefined until written.
`timescale 1ns / 1ps

module page_download_protocol_engine (
    input  logic          clk,
    input  logic          rst_n,
    pdpe_item_if.sink     item,
    pdpe_result_if.source result,
    pdpe_cfg_if.sink      cfg
);
    import pdpe_pkg::*;

    cmd_t cmd;
    sts_t sts;

    pdpe_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (item.valid),
        .in_ready (item.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    pdpe_dp u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .result (result),
        .cfg    (cfg),
        .cmd    (cmd),
        .sts    (sts)
    );
endmodule

@@ hw/rtl/pdpe_ctrl.sv @@
// ----------------------------------------------------------------------------
// pdpe_ctrl
// Controller: sequences item intake, result loads and page drain.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pdpe_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  pdpe_pkg::sts_t sts,
    output pdpe_pkg::cmd_t cmd
);
    import pdpe_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (sts.dec_burn)
                begin
                    state_next = S_BURN_RD;
                end
                else if (sts.dec_main)
                begin
                    state_next = S_MAIN;
                end
                else if (sts.dec_seed)
                begin
                    state_next = S_SEED;
                end
                else if (sts.dec_tmo)
                begin
                    state_next = S_TMO;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_MAIN:
            begin
                if (sts.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            S_SEED:
            begin
                if (sts.out_free)
                begin
                    state_next = sts.dec_tmo ? S_TMO : S_IDLE;
                end
            end
            S_TMO:
            begin
                if (sts.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            S_BURN_RD:
            begin
                state_next = S_BURN_LD;
            end
            S_BURN_LD:
            begin
                if (sts.out_free)
                begin
                    state_next = sts.idx_last ? S_IDLE : S_BURN_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd       = '0;
        cmd.load  = LD_NONE;
        in_ready  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.take_in = in_valid;
            end
            S_DECIDE:
            begin
                cmd.idx_clr = 1'b1;
            end
            S_MAIN:
            begin
                if (sts.out_free)
                begin
                    cmd.load      = LD_MAIN;
                    cmd.load_last = 1'b1;
                end
            end
            S_SEED:
            begin
                if (sts.out_free)
                begin
                    cmd.load      = LD_SEED;
                    cmd.load_last = !sts.dec_tmo;
                end
            end
            S_TMO:
            begin
                if (sts.out_free)
                begin
                    cmd.load      = LD_TMO;
                    cmd.load_last = 1'b1;
                end
            end
            S_BURN_RD:
            begin
                cmd.rd_en = 1'b1;
            end
            S_BURN_LD:
            begin
                if (sts.out_free)
                begin
                    cmd.load      = LD_BURN;
                    cmd.load_last = sts.idx_last;
                    cmd.idx_inc   = !sts.idx_last;
                end
            end
            default:
            begin
                cmd.load = LD_NONE;
            end
        endcase
    end

    `PDPE_ASSERT_NEXT(a_take_decide, cmd.take_in, state_reg == S_DECIDE)
    `PDPE_ASSERT(a_load_free, (cmd.load == LD_NONE) || sts.out_free)
    `PDPE_ASSERT_NEXT(a_burn_end, (cmd.load == LD_BURN) && sts.idx_last, state_reg == S_IDLE)
endmodule

@@ hw/rtl/pdpe_dp.sv @@
// ----------------------------------------------------------------------------
// pdpe_dp
// Datapath: protocol state, page buffer, decisions and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pdpe_dp (
    input  logic           clk,
    input  logic           rst_n,
    pdpe_item_if.sink      item,
    pdpe_result_if.source  result,
    pdpe_cfg_if.sink       cfg,
    input  pdpe_pkg::cmd_t cmd,
    output pdpe_pkg::sts_t sts
);
    import pdpe_pkg::*;

    logic [7:0]  push_hdr_reg, seed_hdr_reg, pull_hdr_reg, done_rld_reg, seed_rld_reg;
    logic        root_en_reg;
    logic [7:0]  root_pages_reg;
    logic [15:0] root_cs_reg;

    logic [7:0]       byte_count_reg, byte_count_next;
    logic [7:0]       header_reg, header_next;
    logic [7:0]       sum_reg, sum_next;
    logic [7:0]       field_reg [3];
    logic [7:0]       field_next [3];
    logic [7:0]       pages_total_reg, pages_total_next;
    logic [8:0]       next_page_reg, next_page_next;
    logic [SRC_W-1:0] source_face_reg, source_face_next;
    logic [15:0]      offered_cs_reg, offered_cs_next;
    logic [2:0]       seed_face_reg, seed_face_next;
    logic [7:0]       prescaler_reg, prescaler_next;
    logic [7:0]       seed_cd_reg, seed_cd_next;
    logic [7:0]       done_cd_reg, done_cd_next;

    logic       dec_main_reg, dec_main_next;
    logic       dec_seed_reg, dec_seed_next;
    logic       dec_tmo_reg, dec_tmo_next;
    logic       dec_burn_reg, dec_burn_next;
    logic [2:0] main_act_reg, main_act_next;
    logic [2:0] main_face_reg, main_face_next;
    logic [7:0] main_page_reg, main_page_next;

    logic [7:0] bank_lo [BANK_D];
    logic [7:0] bank_hi [BANK_D];
    logic [7:0] rd_lo_reg, rd_hi_reg;
    logic [5:0] idx_reg;
    logic       wr_en;
    logic [7:0] pm1;
    logic [8:0] off9;

    logic        out_valid_reg;
    logic [2:0]  out_act_reg, out_face_reg;
    logic [7:0]  out_page_reg, out_total_reg;
    logic [5:0]  out_idx_reg;
    logic [15:0] out_data_reg, out_cs_reg;
    logic        out_complete_reg, out_last_reg;

    logic [7:0] pg, req;
    logic [8:0] np1;

    function automatic logic [7:0] byte_count_next_pre(input logic [7:0] bc);
        return (bc == 8'd255) ? 8'd255 : bc + 8'd1;
    endfunction

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            push_hdr_reg   <= 8'd1;
            seed_hdr_reg   <= 8'd2;
            pull_hdr_reg   <= 8'd3;
            done_rld_reg   <= 8'd11;
            seed_rld_reg   <= 8'd1;
            root_en_reg    <= 1'b0;
            root_pages_reg <= 8'd112;
            root_cs_reg    <= 16'd0;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_PUSH_HDR:   push_hdr_reg   <= cfg.data[7:0];
                REG_SEED_HDR:   seed_hdr_reg   <= cfg.data[7:0];
                REG_PULL_HDR:   pull_hdr_reg   <= cfg.data[7:0];
                REG_DONE_RLD:   done_rld_reg   <= cfg.data[7:0];
                REG_SEED_RLD:   seed_rld_reg   <= cfg.data[7:0];
                REG_ROOT_EN:    root_en_reg    <= cfg.data[0];
                REG_ROOT_PAGES: root_pages_reg <= cfg.data[7:0];
                REG_ROOT_CS:    root_cs_reg    <= cfg.data;
                default:        root_cs_reg    <= root_cs_reg;
            endcase
        end
    end

    assign pm1  = byte_count_reg - 8'd1;
    assign off9 = {1'b0, pm1} - 9'(PAGE_BYTES);

    always_comb
    begin
        byte_count_next  = byte_count_reg;
        header_next      = header_reg;
        sum_next         = sum_reg;
        field_next       = field_reg;
        pages_total_next = pages_total_reg;
        next_page_next   = next_page_reg;
        source_face_next = source_face_reg;
        offered_cs_next  = offered_cs_reg;
        seed_face_next   = seed_face_reg;
        prescaler_next   = prescaler_reg;
        seed_cd_next     = seed_cd_reg;
        done_cd_next     = done_cd_reg;
        dec_main_next    = 1'b0;
        dec_seed_next    = 1'b0;
        dec_tmo_next     = 1'b0;
        dec_burn_next    = 1'b0;
        main_act_next    = main_act_reg;
        main_face_next   = item.face;
        main_page_next   = 8'd0;
        wr_en            = 1'b0;
        pg               = 8'd0;
        req              = 8'd0;
        np1              = 9'd0;
        if (cmd.take_in)
        begin
            case (item.mode)
                MODE_BYTE:
                begin
                    if (byte_count_reg != 8'd255)
                    begin
                        byte_count_next = byte_count_reg + 8'd1;
                    end
                    if (byte_count_reg == 8'd0)
                    begin
                        header_next = item.data_byte;
                    end
                    else if (header_reg == push_hdr_reg)
                    begin
                        if ({1'b0, pm1} < 9'(PAGE_BYTES))
                        begin
                            wr_en = 1'b1;
                        end
                        else if (off9 < 9'd3)
                        begin
                            field_next[off9[1:0]] = item.data_byte;
                        end
                    end
                    else if (pm1 < 8'd3)
                    begin
                        field_next[pm1[1:0]] = item.data_byte;
                    end
                    if (item.last_byte)
                    begin
                        byte_count_next = 8'd0;
                        sum_next        = 8'd0;
                        if (header_next == push_hdr_reg)
                        begin
                            if ({2'b0, byte_count_next_pre(byte_count_reg)}
                                == 10'(PAGE_BYTES + 3))
                            begin
                                pg             = field_next[0];
                                main_page_next = pg;
                                if ({1'b0, pg} != next_page_reg)
                                begin
                                    dec_main_next = 1'b1;
                                    main_act_next = ACT_ORDER;
                                end
                                else if ((sum_reg ^ 8'hff) != item.data_byte)
                                begin
                                    dec_main_next = 1'b1;
                                    main_act_next = ACT_CHECKSUM;
                                end
                                else
                                begin
                                    dec_burn_next = 1'b1;
                                    np1 = next_page_reg + 9'd1;
                                    if (np1 == {1'b0, pages_total_reg})
                                    begin
                                        next_page_next = np1 + 9'd1;
                                    end
                                    else
                                    begin
                                        next_page_next = np1;
                                        done_cd_next   = done_rld_reg;
                                    end
                                end
                            end
                            else
                            begin
                                dec_main_next = 1'b1;
                                main_act_next = ACT_BAD;
                            end
                        end
                        else if (header_next == seed_hdr_reg)
                        begin
                            if (next_page_reg <= {1'b0, pages_total_reg})
                            begin
                                dec_main_next = 1'b1;
                                if (byte_count_next_pre(byte_count_reg) == 8'd4)
                                begin
                                    main_act_next = ACT_PULL;
                                    if (pages_total_reg == 8'd0)
                                    begin
                                        pages_total_next = field_next[0];
                                        offered_cs_next  = {field_next[2], field_next[1]};
                                        source_face_next = SRC_W'(item.face);
                                        seed_face_next   = stagger(item.face);
                                        main_face_next   = item.face;
                                    end
                                    else
                                    begin
                                        main_face_next = 3'(source_face_reg);
                                    end
                                    main_page_next = next_page_reg[7:0];
                                end
                                else
                                begin
                                    main_act_next = ACT_BAD;
                                end
                            end
                        end
                        else if (header_next == pull_hdr_reg)
                        begin
                            if (byte_count_next_pre(byte_count_reg) == 8'd2)
                            begin
                                req = field_next[0];
                                if ({1'b0, req} < next_page_reg)
                                begin
                                    dec_main_next  = 1'b1;
                                    main_act_next  = ACT_PUSH;
                                    main_page_next = req;
                                    seed_cd_next   = 8'd0;
                                    done_cd_next   = done_rld_reg;
                                end
                            end
                            else
                            begin
                                dec_main_next = 1'b1;
                                main_act_next = ACT_BAD;
                            end
                        end
                    end
                    else
                    begin
                        sum_next = sum_reg + item.data_byte;
                    end
                end
                MODE_TICK:
                begin
                    prescaler_next = prescaler_reg - 8'd1;
                    if (prescaler_next == 8'd0)
                    begin
                        if (seed_cd_reg != 8'd0)
                        begin
                            seed_cd_next = seed_cd_reg - 8'd1;
                        end
                        if (done_cd_reg != 8'd0)
                        begin
                            done_cd_next = done_cd_reg - 8'd1;
                        end
                    end
                    if (seed_cd_next == 8'd0 && next_page_reg != 9'd0)
                    begin
                        seed_face_next = stagger(seed_face_reg);
                        dec_seed_next  = 1'b1;
                        seed_cd_next   = seed_rld_reg;
                    end
                    dec_tmo_next = (done_cd_next == 8'd0);
                end
                MODE_START:
                begin
                    byte_count_next  = 8'd0;
                    sum_next         = 8'd0;
                    if (root_en_reg)
                    begin
                        offered_cs_next  = root_cs_reg;
                        pages_total_next = root_pages_reg;
                        next_page_next   = {1'b0, root_pages_reg} + 9'd1;
                    end
                    else
                    begin
                        offered_cs_next  = 16'd0;
                        pages_total_next = 8'd0;
                        next_page_next   = 9'd0;
                    end
                    source_face_next = SRC_W'(FACES);
                    done_cd_next     = done_rld_reg;
                    seed_cd_next     = 8'd0;
                end
                default:
                begin
                    prescaler_next = prescaler_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg  <= 8'd0;
            header_reg      <= 8'd0;
            sum_reg         <= 8'd0;
            field_reg       <= '{8'd0, 8'd0, 8'd0};
            pages_total_reg <= 8'd0;
            next_page_reg   <= 9'd0;
            source_face_reg <= SRC_W'(FACES);
            offered_cs_reg  <= 16'd0;
            seed_face_reg   <= 3'd0;
            prescaler_reg   <= 8'd0;
            seed_cd_reg     <= 8'd0;
            done_cd_reg     <= 8'd11;
            dec_main_reg    <= 1'b0;
            dec_seed_reg    <= 1'b0;
            dec_tmo_reg     <= 1'b0;
            dec_burn_reg    <= 1'b0;
            idx_reg         <= 6'd0;
        end
        else
        begin
            byte_count_reg  <= byte_count_next;
            header_reg      <= header_next;
            sum_reg         <= sum_next;
            field_reg       <= field_next;
            pages_total_reg <= pages_total_next;
            next_page_reg   <= next_page_next;
            source_face_reg <= source_face_next;
            offered_cs_reg  <= offered_cs_next;
            seed_face_reg   <= seed_face_next;
            prescaler_reg   <= prescaler_next;
            seed_cd_reg     <= seed_cd_next;
            done_cd_reg     <= done_cd_next;
            if (cmd.take_in)
            begin
                dec_main_reg <= dec_main_next;
                dec_seed_reg <= dec_seed_next;
                dec_tmo_reg  <= dec_tmo_next;
                dec_burn_reg <= dec_burn_next;
            end
            if (cmd.idx_clr)
            begin
                idx_reg <= 6'd0;
            end
            else if (cmd.idx_inc)
            begin
                idx_reg <= idx_reg + 6'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take_in)
        begin
            main_act_reg  <= main_act_next;
            main_face_reg <= main_face_next;
            main_page_reg <= main_page_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            if (pm1[0])
            begin
                bank_hi[pm1[BANK_AW:1]] <= item.data_byte;
            end
            else
            begin
                bank_lo[pm1[BANK_AW:1]] <= item.data_byte;
            end
        end
        if (cmd.rd_en)
        begin
            rd_lo_reg <= bank_lo[BANK_AW'(idx_reg)];
            rd_hi_reg <= bank_hi[BANK_AW'(idx_reg)];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load != LD_NONE)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load != LD_NONE)
        begin
            out_act_reg      <= ACT_TIMEOUT;
            out_face_reg     <= 3'd0;
            out_page_reg     <= 8'd0;
            out_idx_reg      <= 6'd0;
            out_data_reg     <= 16'd0;
            out_total_reg    <= 8'd0;
            out_cs_reg       <= 16'd0;
            out_complete_reg <= next_page_reg > {1'b0, pages_total_reg};
            out_last_reg     <= cmd.load_last;
            case (cmd.load)
                LD_MAIN:
                begin
                    out_act_reg  <= main_act_reg;
                    out_face_reg <= main_face_reg;
                    out_page_reg <= main_page_reg;
                end
                LD_SEED:
                begin
                    out_act_reg   <= ACT_SEED;
                    out_face_reg  <= seed_face_reg;
                    out_total_reg <= pages_total_reg;
                    out_cs_reg    <= offered_cs_reg;
                end
                LD_BURN:
                begin
                    out_act_reg  <= ACT_BURN;
                    out_face_reg <= main_face_reg;
                    out_page_reg <= main_page_reg;
                    out_idx_reg  <= idx_reg;
                    out_data_reg <= {rd_hi_reg, rd_lo_reg};
                end
                default:
                begin
                    out_act_reg <= ACT_TIMEOUT;
                end
            endcase
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.action        = out_act_reg;
    assign result.target_face   = out_face_reg;
    assign result.page          = out_page_reg;
    assign result.word_index    = out_idx_reg;
    assign result.word_data     = out_data_reg;
    assign result.seed_pages    = out_total_reg;
    assign result.seed_checksum = out_cs_reg;
    assign result.complete      = out_complete_reg;
    assign result.last          = out_last_reg;

    assign sts.dec_main = dec_main_reg;
    assign sts.dec_seed = dec_seed_reg;
    assign sts.dec_tmo  = dec_tmo_reg;
    assign sts.dec_burn = dec_burn_reg;
    assign sts.out_free = !out_valid_reg || result.ready;
    assign sts.idx_last = (idx_reg == 6'(NWORDS - 1));
endmodule
